>>> rtl/core/fltw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the four-level page table walker.
// No dependencies.
package fltw_pkg;

    localparam int VA_W    = 64;
    localparam int DATA_W  = 64;
    localparam int VA48_W  = 48;
    localparam int IDX_W   = 9;
    localparam int PAGE_W  = 12;
    localparam int LEVEL_W = 2;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;

    localparam logic [31:0] MEM_ORIGIN_RESET = 32'h4000_0000;
    localparam logic [32:0] WINDOW_LEN_RESET = 33'h0_4000_0000;
    localparam logic [31:0] ROOT_TBL_RESET   = 32'h0113_D000;

    // Top 17 bits all ones mark the linear window base region
    localparam logic [16:0] LINEAR_TOP = 17'h1_FFFF;

    localparam logic [LEVEL_W-1:0] LAST_LEVEL = 2'd3;

    typedef enum logic [1:0] {
        REG_MEM_ORIGIN = 2'd0,
        REG_WINDOW_LEN = 2'd1,
        REG_ROOT_TBL   = 2'd2
    } reg_index_t;

    typedef enum logic {
        OP_TRANSLATE = 1'b0,
        OP_RESPONSE  = 1'b1
    } op_t;

    typedef enum logic {
        KIND_READ   = 1'b0,
        KIND_RESULT = 1'b1
    } kind_t;

    typedef struct packed {
        op_t               op;
        logic [VA_W-1:0]   virtual_address;
        logic [DATA_W-1:0] read_data;
    } item_t;

    typedef struct packed {
        kind_t              kind;
        logic [VA_W-1:0]    address;
        logic [LEVEL_W-1:0] walk_level;
    } result_t;

    // Entry offset (index * 8) of a table level
    function automatic logic [PAGE_W-1:0] entry_offset(input logic [VA48_W-1:0] va,
                                                      input logic [LEVEL_W-1:0] lvl);
        logic [IDX_W-1:0] idx;
        begin
            case (lvl)
                2'd0:    idx = va[47:39];
                2'd1:    idx = va[38:30];
                2'd2:    idx = va[29:21];
                default: idx = va[20:12];
            endcase
            entry_offset = {idx, 3'b000};
        end
    endfunction

endpackage

>>> rtl/core/four_level_page_table_walker.sv
`timescale 1ns / 1ps
// A result word is registered in the output register, or in the skid entry if stalled.
// Throughput: one word per cycle while the skid is empty; a two-entry output (register
// plus skid) keeps the input open while one result waits. Walk state updates on accept.
// Reset (rst_n, async, active low): idle, level 0, outputs empty, registers at defaults.
// Top level of the page table walker; uses fltw_pkg.
module four_level_page_table_walker
    import fltw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  item_t              item,
    output logic               result_valid,
    input  logic               result_stall,
    output result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [31:0]         mem_origin_reg, mem_origin_next;
    logic [32:0]         window_len_reg, window_len_next;
    logic [31:0]         root_tbl_reg, root_tbl_next;
    logic                busy_reg, busy_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic [VA48_W-1:0]   saved_reg, saved_next;
    result_t             out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    result_t             skid_reg, skid_next;
    logic                skid_valid_reg, skid_valid_next;

    logic                accept;
    logic                cfg_write;
    reg_index_t          cfg_idx;
    logic                in_window;
    logic [VA_W-1:0]     entry_base;
    logic [LEVEL_W-1:0]  level_inc;
    logic                res_fire;
    result_t             res_word;

    assign pready     = 1'b1;
    assign item_stall = skid_valid_reg;
    assign accept     = item_valid && !item_stall;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign cfg_idx    = reg_index_t'(paddr[4:3]);

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        case (cfg_idx)
            REG_MEM_ORIGIN: prdata = {32'd0, mem_origin_reg};
            REG_WINDOW_LEN: prdata = {31'd0, window_len_reg};
            REG_ROOT_TBL:   prdata = {32'd0, root_tbl_reg};
            default:        prdata = '0;
        endcase
    end

    always_comb
    begin
        mem_origin_next = mem_origin_reg;
        window_len_next = window_len_reg;
        root_tbl_next   = root_tbl_reg;
        if (cfg_write)
        begin
            case (cfg_idx)
                REG_MEM_ORIGIN: mem_origin_next = pwdata[31:0];
                REG_WINDOW_LEN: window_len_next = pwdata[32:0];
                REG_ROOT_TBL:   root_tbl_next   = pwdata[31:0];
                default:        ;
            endcase
        end
    end

    // Window: top 17 bits set and the offset above the base no larger than the window length
    assign in_window = (item.virtual_address[63:47] == LINEAR_TOP)
                    && (item.virtual_address[46:33] == '0)
                    && (item.virtual_address[32:0] <= window_len_reg);

    assign entry_base = {32'd0, item.read_data[31:12], 12'd0} - {32'd0, mem_origin_reg};
    assign level_inc  = level_reg + 2'd1;

    always_comb
    begin
        busy_next           = busy_reg;
        level_next          = level_reg;
        saved_next          = saved_reg;
        res_fire            = 1'b0;
        res_word.kind       = KIND_READ;
        res_word.address    = '0;
        res_word.walk_level = '0;
        if (accept)
        begin
            if (item.op == OP_TRANSLATE)
            begin
                if (!busy_reg)
                begin
                    res_fire = 1'b1;
                    if (in_window)
                    begin
                        res_word.kind    = KIND_RESULT;
                        res_word.address = {32'd0, item.virtual_address[31:0]};
                    end
                    else
                    begin
                        busy_next        = 1'b1;
                        level_next       = '0;
                        saved_next       = item.virtual_address[VA48_W-1:0];
                        res_word.address = {31'd0, {1'b0, root_tbl_reg}
                            + {21'd0, entry_offset(item.virtual_address[VA48_W-1:0], 2'd0)}};
                    end
                end
            end
            else if (busy_reg)
            begin
                res_fire = 1'b1;
                if (level_reg != LAST_LEVEL)
                begin
                    level_next          = level_inc;
                    res_word.address    = entry_base
                        + {52'd0, entry_offset(saved_reg, level_inc)};
                    res_word.walk_level = level_inc;
                end
                else
                begin
                    busy_next        = 1'b0;
                    level_next       = '0;
                    res_word.kind    = KIND_RESULT;
                    res_word.address = entry_base | {52'd0, saved_reg[PAGE_W-1:0]};
                end
            end
        end
    end

    // Output register with skid entry
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = skid_valid_reg;
            out_next       = skid_reg;
            skid_valid_next = 1'b0;
        end
        if (res_fire)
        begin
            if (out_valid_reg && result_stall)
            begin
                skid_next       = res_word;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_next       = res_word;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_origin_reg <= MEM_ORIGIN_RESET;
            window_len_reg <= WINDOW_LEN_RESET;
            root_tbl_reg   <= ROOT_TBL_RESET;
            busy_reg       <= 1'b0;
            level_reg      <= '0;
            saved_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            mem_origin_reg <= mem_origin_next;
            window_len_reg <= window_len_next;
            root_tbl_reg   <= root_tbl_next;
            busy_reg       <= busy_next;
            level_reg      <= level_next;
            saved_reg      <= saved_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output word");

    a_level_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (level_reg != '0) |-> busy_reg)
        else $error("nonzero walk level while idle");

    a_drop_keeps_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.op == OP_TRANSLATE && busy_reg)
        |=> ($stable(saved_reg) && $stable(level_reg) && busy_reg))
        else $error("request during walk disturbed walk state");

    a_last_level_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.op == OP_RESPONSE && busy_reg && level_reg == LAST_LEVEL)
        |=> (!busy_reg && out_valid_reg))
        else $error("final response did not end walk");
`endif

endmodule
